/* rtl/fp16_misc_ops_unit_macros.svh */
// assertion macros for the fp16 misc ops unit checker
`ifndef FP16_MISC_OPS_UNIT_MACROS_SVH
`define FP16_MISC_OPS_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define FMO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fmo checker: implication failed");

// invariant checked on every clock edge outside reset
`define FMO_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("fmo checker: invariant failed");

`endif

/* rtl/fmo_pkg.sv */
// shared types, codes and rounding helpers for the fp16 misc ops unit
package fmo_pkg;

    // operation codes
    typedef enum logic [3:0] {
        FN_SGNJ     = 4'd0,
        FN_SGNJN    = 4'd1,
        FN_SGNJX    = 4'd2,
        FN_MIN      = 4'd3,
        FN_MAX      = 4'd4,
        FN_EQ       = 4'd5,
        FN_LT       = 4'd6,
        FN_LE       = 4'd7,
        FN_CVT_H_W  = 4'd8,
        FN_CVT_H_WU = 4'd9,
        FN_CVT_W_H  = 4'd10,
        FN_CVT_WU_H = 4'd11,
        FN_MV_X_H   = 4'd12,
        FN_CLASS    = 4'd13,
        FN_MV_H_X   = 4'd14,
        FN_UNSUP    = 4'd15
    } t_func;

    // rounding mode codes
    typedef logic [2:0] t_rm;
    localparam t_rm RM_RNE = 3'd0;
    localparam t_rm RM_RTZ = 3'd1;
    localparam t_rm RM_RDN = 3'd2;
    localparam t_rm RM_RUP = 3'd3;
    localparam t_rm RM_RMM = 3'd4;
    localparam t_rm RM_DYN = 3'd7;

    // half-precision constants
    localparam logic [14:0] H_INF_MAG  = 15'h7C00;
    localparam logic [14:0] H_MAXF_MAG = 15'h7BFF;
    localparam logic [15:0] H_QNAN     = 16'h7E00;

    // increment decision from kept lsb, round bit and sticky bit
    function automatic logic round_inc(input t_rm rm, input logic neg, input logic lsb,
                                       input logic rb, input logic st);
        logic inc;
        case (rm)
            RM_RNE, RM_DYN: inc = rb & (st | lsb);
            RM_RMM:         inc = rb;
            RM_RDN:         inc = neg & (rb | st);
            RM_RUP:         inc = ~neg & (rb | st);
            RM_RTZ:         inc = 1'b0;
            default:        inc = 1'b0;
        endcase
        return inc;
    endfunction

    // overflow goes to infinity when the mode rounds away from zero
    function automatic logic rounds_away(input t_rm rm, input logic neg);
        logic away;
        case (rm)
            RM_RNE, RM_DYN, RM_RMM: away = 1'b1;
            RM_RUP:                 away = ~neg;
            RM_RDN:                 away = neg;
            default:                away = 1'b0;
        endcase
        return away;
    endfunction

endpackage

/* rtl/fmo_int2half.sv */
// int32 / uint32 to half-precision conversion with rounding
module fmo_int2half (
    input  logic [31:0]      i_op_a,
    input  fmo_pkg::t_rm     i_rm,
    input  logic             i_is_signed,
    output logic [15:0]      o_half
);
    import fmo_pkg::*;

    logic        neg;
    logic [31:0] mag32;
    logic        ovf;
    logic [15:0] mag16;
    logic [3:0]  p;
    logic [15:0] norm;
    logic [4:0]  ex;
    logic        inc;
    logic [10:0] mant_sum;

    // sign and magnitude
    assign neg   = i_is_signed & i_op_a[31];
    assign mag32 = neg ? (32'd0 - i_op_a) : i_op_a;
    assign ovf   = |mag32[31:16];
    assign mag16 = mag32[15:0];

    // leading-one position
    always_comb begin
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag16[i]) p = 4'(i);
        end
    end

    // normalize so the leading one sits at bit 15, then round
    assign norm     = mag16 << (4'd15 - p);
    assign inc      = round_inc(i_rm, neg, norm[5], norm[4], |norm[3:0]);
    assign mant_sum = {1'b0, norm[14:5]} + {10'd0, inc};
    assign ex       = 5'({1'b0, p}) + 5'd15 + {4'd0, mant_sum[10]};

    // pack, carry into exponent 31 yields infinity naturally
    always_comb begin
        if (ovf) begin
            o_half = {neg, rounds_away(i_rm, neg) ? H_INF_MAG : H_MAXF_MAG};
        end else if (mag16 == 16'd0) begin
            o_half = {neg, 15'd0};
        end else begin
            o_half = {neg, ex, mant_sum[9:0]};
        end
    end

endmodule

/* rtl/fmo_half2int.sv */
// half-precision to int32 / uint32 conversion with rounding and saturation
module fmo_half2int (
    input  logic [15:0]      i_half,
    input  fmo_pkg::t_rm     i_rm,
    input  logic             i_is_unsigned,
    output logic [31:0]      o_word
);
    import fmo_pkg::*;

    logic        neg;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [10:0] sig;
    logic [2:0]  sh_l;
    logic [4:0]  sh_r;
    logic [15:0] big;
    logic [34:0] frac;
    logic        inc;
    logic [15:0] small_mag;
    logic [15:0] mag;

    assign neg = i_half[15];
    assign ex  = i_half[14:10];
    assign man = i_half[9:0];
    assign sig = {1'b1, man};

    // large exponents shift left, no rounding needed
    assign sh_l = 3'(ex - 5'd25);
    assign big  = {5'd0, sig} << sh_l;

    // small exponents shift right and round on the dropped bits
    assign sh_r      = 5'd25 - ex;
    assign frac      = {sig, 24'd0} >> sh_r;
    assign inc       = round_inc(i_rm, neg, frac[24], frac[23], |frac[22:0]);
    assign small_mag = {5'd0, frac[34:24]} + {15'd0, inc};

    assign mag = (ex >= 5'd25) ? big : small_mag;

    // special values and sign
    always_comb begin
        if (i_is_unsigned) begin
            if (neg)                o_word = 32'h0000_0000;
            else if (ex == 5'd31)   o_word = 32'hFFFF_FFFF;
            else if (ex == 5'd0)    o_word = 32'h0000_0000;
            else                    o_word = {16'd0, mag};
        end else begin
            if (ex == 5'd31) begin
                o_word = (man == 10'd0 && neg) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (ex == 5'd0) begin
                o_word = 32'h0000_0000;
            end else begin
                o_word = neg ? (32'd0 - {16'd0, mag}) : {16'd0, mag};
            end
        end
    end

endmodule

/* rtl/fmo_sgn_cmp.sv */
// sign injection, min/max, compares, classify and moves on half operands
module fmo_sgn_cmp (
    input  fmo_pkg::t_func   i_func,
    input  logic [15:0]      i_a,
    input  logic [15:0]      i_b,
    output logic [31:0]      o_word
);
    import fmo_pkg::*;

    logic        a_nan, b_nan;
    logic [14:0] ma, mb;
    logic        both_zero;
    logic        a_lt_b, b_lt_a;
    logic [15:0] min_v, max_v;
    logic [9:0]  cls;

    assign ma        = i_a[14:0];
    assign mb        = i_b[14:0];
    assign a_nan     = (i_a[14:10] == 5'h1F) && (i_a[9:0] != 10'd0);
    assign b_nan     = (i_b[14:10] == 5'h1F) && (i_b[9:0] != 10'd0);
    assign both_zero = (ma == 15'd0) && (mb == 15'd0);

    // ordering on sign-magnitude values, zeros of opposite sign not less
    always_comb begin
        if (i_a[15] != i_b[15]) begin
            a_lt_b = i_a[15] & ~both_zero;
            b_lt_a = i_b[15] & ~both_zero;
        end else if (i_a[15]) begin
            a_lt_b = mb < ma;
            b_lt_a = ma < mb;
        end else begin
            a_lt_b = ma < mb;
            b_lt_a = mb < ma;
        end
    end

    // min and max with nan and signed zero handling
    always_comb begin
        if (a_nan && b_nan) begin
            min_v = H_QNAN;
            max_v = H_QNAN;
        end else if (a_nan) begin
            min_v = i_b;
            max_v = i_b;
        end else if (b_nan) begin
            min_v = i_a;
            max_v = i_a;
        end else if (both_zero) begin
            min_v = {i_a[15] | i_b[15], 15'd0};
            max_v = {i_a[15] & i_b[15], 15'd0};
        end else begin
            min_v = b_lt_a ? i_b : i_a;
            max_v = a_lt_b ? i_b : i_a;
        end
    end

    // class mask
    always_comb begin
        if (i_a[14:10] == 5'h1F) begin
            if (i_a[9:0] == 10'd0) cls = i_a[15] ? 10'h001 : 10'h080;
            else                   cls = i_a[9] ? 10'h200 : 10'h100;
        end else if (i_a[14:10] == 5'd0) begin
            if (i_a[9:0] == 10'd0) cls = i_a[15] ? 10'h008 : 10'h010;
            else                   cls = i_a[15] ? 10'h004 : 10'h020;
        end else begin
            cls = i_a[15] ? 10'h002 : 10'h040;
        end
    end

    // result select
    always_comb begin
        case (i_func)
            FN_SGNJ:   o_word = {16'd0, i_b[15], ma};
            FN_SGNJN:  o_word = {16'd0, ~i_b[15], ma};
            FN_SGNJX:  o_word = {16'd0, i_a[15] ^ i_b[15], ma};
            FN_MIN:    o_word = {16'd0, min_v};
            FN_MAX:    o_word = {16'd0, max_v};
            FN_EQ:     o_word = {31'd0, ~a_nan & ~b_nan & ((i_a == i_b) | both_zero)};
            FN_LT:     o_word = {31'd0, ~a_nan & ~b_nan & a_lt_b};
            FN_LE:     o_word = {31'd0, ~a_nan & ~b_nan & ~b_lt_a};
            FN_MV_X_H: o_word = {{16{i_a[15]}}, i_a};
            FN_CLASS:  o_word = {22'd0, cls};
            FN_MV_H_X: o_word = {16'd0, i_a};
            default:   o_word = 32'd0;
        endcase
    end

endmodule

/* rtl/fp16_misc_ops_unit.sv */
// top level of the fp16 convert / compare / classify unit
// Takes one request per clock: a request is taken at every rising edge with start high,
// and busy is always low. The result appears on o_result and o_illegal with o_valid high
// for exactly one cycle, once the request has passed the input register and then the
// conversion/compare logic into the result register. The receiver cannot stall the
// unit, so a result must be captured in the cycle it is shown.
// o_illegal marks the unsupported operation code, with a zero result.
module fp16_misc_ops_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_func,
    input  logic [2:0]  i_rounding_mode,
    input  logic [31:0] i_op_a,
    input  logic [15:0] i_op_b,
    output logic        o_valid,
    output logic [31:0] o_result,
    output logic        o_illegal
);
    import fmo_pkg::*;

    logic        r_in_valid;
    t_func       r_func;
    t_rm         r_rm;
    logic [31:0] r_op_a;
    logic [15:0] r_op_b;

    logic        r_out_valid;
    logic [31:0] r_result;
    logic        r_illegal;

    logic [31:0] n_result;
    logic        n_illegal;

    logic [15:0] i2h_half;
    logic [31:0] h2i_word;
    logic [31:0] cmp_word;

    // no backpressure on either side
    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        if (start && !busy) begin
            r_func <= t_func'(i_func);
            r_rm   <= i_rounding_mode;
            r_op_a <= i_op_a;
            r_op_b <= i_op_b;
        end
    end

    // datapath units
    fmo_int2half u_int2half (
        .i_op_a      (r_op_a),
        .i_rm        (r_rm),
        .i_is_signed (r_func == FN_CVT_H_W),
        .o_half      (i2h_half)
    );

    fmo_half2int u_half2int (
        .i_half        (r_op_a[15:0]),
        .i_rm          (r_rm),
        .i_is_unsigned (r_func == FN_CVT_WU_H),
        .o_word        (h2i_word)
    );

    fmo_sgn_cmp u_sgn_cmp (
        .i_func (r_func),
        .i_a    (r_op_a[15:0]),
        .i_b    (r_op_b),
        .o_word (cmp_word)
    );

    // result select
    always_comb begin
        n_illegal = 1'b0;
        case (r_func)
            FN_CVT_H_W, FN_CVT_H_WU:  n_result = {16'd0, i2h_half};
            FN_CVT_W_H, FN_CVT_WU_H:  n_result = h2i_word;
            FN_UNSUP: begin
                n_result  = 32'd0;
                n_illegal = 1'b1;
            end
            default:                  n_result = cmp_word;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_illegal   <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
            r_illegal   <= r_in_valid & n_illegal;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_result  = r_result;
    assign o_illegal = r_illegal;

endmodule

/* rtl/fmo_checker.sv */
// port-level checker for the fp16 misc ops unit and its bind
`include "fp16_misc_ops_unit_macros.svh"

module fmo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [3:0]  i_func,
    input logic        o_valid,
    input logic [31:0] o_result,
    input logic        o_illegal
);
    import fmo_pkg::*;

    // every request yields a shown result
    `FMO_ASSERT_IMP(a_req_to_result, start && !busy, ##2 o_valid)
    // no result without an earlier request
    `FMO_ASSERT_IMP(a_result_has_req, o_valid, $past(start && !busy, 2))
    // illegal flag only on a shown result, with zero data
    `FMO_ASSERT_IMP(a_illegal_zero, o_illegal, o_valid && o_result == 32'd0)
    // illegal flag traces back to the unsupported code
    `FMO_ASSERT_IMP(a_illegal_code, o_valid && $past(i_func, 2) == FN_UNSUP, o_illegal)

endmodule

bind fp16_misc_ops_unit fmo_checker u_fmo_checker (.*);

/* sim/fp16_misc_ops_unit_test.sv */
// self-checking testbench for the fp16 convert / compare / classify unit
module fp16_misc_ops_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fmo_pkg::*;

    // rounding codes that simply truncate
    localparam t_rm RM_TRUNC5 = 3'd5;
    localparam t_rm RM_TRUNC6 = 3'd6;

    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 550;
    localparam int QUIET_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int NUM_ROWS     = 26;

    // what one request should produce
    typedef struct packed {
        t_func       func;
        logic [31:0] result;
        logic        illegal;
    } t_outcome;

    // one directed request, with a typed-in result where it is obvious
    typedef struct packed {
        t_func       func;
        t_rm         rm;
        logic [31:0] op_a;
        logic [15:0] op_b;
        logic        fixed;
        logic [31:0] result;
        logic        illegal;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_func = '0;
    logic [2:0]  i_rounding_mode = '0;
    logic [31:0] i_op_a = '0;
    logic [15:0] i_op_b = '0;
    logic        o_valid;
    logic [31:0] o_result;
    logic        o_illegal;

    t_outcome pending_outcomes[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;

    t_stim_row directed_rows [0:NUM_ROWS-1] = '{
        '{FN_UNSUP,    RM_RNE,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'h0000_0000, 1'b1},
        '{FN_SGNJ,     RM_RNE,    32'hFFFF_3C00, 16'h8000, 1'b1, 32'h0000_BC00, 1'b0},
        '{FN_SGNJN,    RM_RTZ,    32'h0000_3C00, 16'h8000, 1'b1, 32'h0000_3C00, 1'b0},
        '{FN_SGNJX,    RM_RDN,    32'h1234_BC00, 16'h8000, 1'b1, 32'h0000_3C00, 1'b0},
        '{FN_MIN,      RM_RNE,    32'h0000_0000, 16'h8000, 1'b1, 32'h0000_8000, 1'b0},
        '{FN_MAX,      RM_RNE,    32'h0000_8000, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{FN_MIN,      RM_RNE,    32'h0000_7E00, 16'h3C00, 1'b1, 32'h0000_3C00, 1'b0},
        '{FN_MAX,      RM_RNE,    32'h0000_7D00, 16'hFE01, 1'b1, 32'h0000_7E00, 1'b0},
        '{FN_EQ,       RM_RNE,    32'hFFFF_0000, 16'h8000, 1'b1, 32'h0000_0001, 1'b0},
        '{FN_EQ,       RM_RNE,    32'h0000_7E00, 16'h7E00, 1'b1, 32'h0000_0000, 1'b0},
        '{FN_LT,       RM_RNE,    32'h0000_BC00, 16'h3C00, 1'b0, 32'h0,         1'b0},
        '{FN_LE,       RM_RNE,    32'h0000_7C01, 16'h3C00, 1'b1, 32'h0000_0000, 1'b0},
        '{FN_LT,       RM_RNE,    32'h0000_8000, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{FN_CVT_H_W,  RM_RNE,    32'h7FFF_FFFF, 16'h0000, 1'b1, 32'h0000_7C00, 1'b0},
        '{FN_CVT_H_W,  RM_RTZ,    32'h8000_0000, 16'h0000, 1'b1, 32'h0000_FBFF, 1'b0},
        '{FN_CVT_H_WU, RM_RUP,    32'hFFFF_FFFF, 16'h0000, 1'b1, 32'h0000_7C00, 1'b0},
        '{FN_CVT_H_W,  RM_DYN,    32'h0000_FFF0, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{FN_CVT_H_W,  RM_RMM,    32'h0000_0000, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{FN_CVT_W_H,  RM_RNE,    32'h0000_7C00, 16'h0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{FN_CVT_W_H,  RM_RNE,    32'h0000_FC00, 16'h0000, 1'b1, 32'h8000_0000, 1'b0},
        '{FN_CVT_WU_H, RM_RNE,    32'h0000_7E00, 16'h0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{FN_CVT_WU_H, RM_RUP,    32'h0000_BC00, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{FN_CVT_W_H,  RM_RUP,    32'h0000_03FF, 16'h0000, 1'b1, 32'h0000_0000, 1'b0},
        '{FN_CVT_W_H,  RM_TRUNC6, 32'h0000_3E00, 16'h0000, 1'b0, 32'h0,         1'b0},
        '{FN_MV_X_H,   RM_TRUNC5, 32'h1234_8000, 16'h0000, 1'b1, 32'hFFFF_8000, 1'b0},
        '{FN_CLASS,    RM_RNE,    32'h0000_7D00, 16'h0000, 1'b1, 32'h0000_0100, 1'b0}
    };

    fp16_misc_ops_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_rounding_mode (i_rounding_mode),
        .i_op_a          (i_op_a),
        .i_op_b          (i_op_b),
        .o_valid         (o_valid),
        .o_result        (o_result),
        .o_illegal       (o_illegal)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic logic half_is_nan(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'h0);
    endfunction

    // whether the kept magnitude goes up by one
    function automatic logic round_up_needed(input t_rm rm, input logic neg, input logic lsb,
                                             input logic rb, input logic st);
        case (rm)
            RM_RNE, RM_DYN: return rb && (st || lsb);
            RM_RMM:         return rb;
            RM_RDN:         return neg && (rb || st);
            RM_RUP:         return !neg && (rb || st);
            default:        return 1'b0;
        endcase
    endfunction

    // overflow of an integer goes to infinity only when rounding away from zero
    function automatic logic overflow_to_inf(input t_rm rm, input logic neg);
        case (rm)
            RM_RNE, RM_DYN, RM_RMM: return 1'b1;
            RM_RUP:                 return !neg;
            RM_RDN:                 return neg;
            default:                return 1'b0;
        endcase
    endfunction

    // integer magnitude plus sign to half
    function automatic logic [15:0] half_from_magnitude(input logic [31:0] mag, input logic neg,
                                                        input t_rm rm);
        int          msb;
        int          sh;
        logic [5:0]  ex;
        logic [10:0] mant;
        logic [31:0] frac;
        logic        rb;
        logic        st;
        msb = 0;
        if (mag == 32'h0) return {neg, 15'h0};
        for (int i = 0; i < 32; i++)
            if (mag[i]) msb = i;
        if (msb >= 16) return {neg, overflow_to_inf(rm, neg) ? H_INF_MAG : H_MAXF_MAG};
        ex   = 6'(msb + 15);
        frac = mag & ((32'd1 << msb) - 32'd1);
        if (msb <= 10) begin
            mant = 11'(frac << (10 - msb));
        end else begin
            sh   = msb - 10;
            rb   = frac[sh-1];
            st   = (frac & ((32'd1 << (sh - 1)) - 32'd1)) != 32'h0;
            mant = 11'(frac >> sh);
            if (round_up_needed(rm, neg, mant[0], rb, st)) begin
                mant = mant + 11'd1;
                if (mant == 11'h400) begin
                    mant = 11'h0;
                    ex   = ex + 6'd1;
                end
            end
            if (ex >= 6'd31) return {neg, H_INF_MAG};
        end
        return {neg, ex[4:0], mant[9:0]};
    endfunction

    // rounded integer magnitude of a normal finite half
    function automatic logic [31:0] magnitude_from_half(input logic [15:0] h, input t_rm rm);
        int          ex;
        int          sh;
        logic [31:0] sig;
        logic [31:0] mag;
        logic [31:0] rem;
        ex  = int'(h[14:10]);
        sig = {21'h0, 1'b1, h[9:0]};
        if (ex >= 25) return sig << (ex - 25);
        sh  = 25 - ex;
        mag = sig >> sh;
        rem = sig & ((32'd1 << sh) - 32'd1);
        if (round_up_needed(rm, h[15], mag[0], rem[sh-1],
                            (rem & ((32'd1 << (sh - 1)) - 32'd1)) != 32'h0))
            mag = mag + 32'd1;
        return mag;
    endfunction

    function automatic logic half_less(input logic [15:0] a, input logic [15:0] b);
        if (a[15] != b[15]) return a[15] ? (a[14:0] != 15'h0 || b[14:0] != 15'h0) : 1'b0;
        return a[15] ? (b[14:0] < a[14:0]) : (a[14:0] < b[14:0]);
    endfunction

    function automatic logic [15:0] pick_min_max(input logic [15:0] a, input logic [15:0] b,
                                                 input logic want_max);
        if (half_is_nan(a) && half_is_nan(b)) return H_QNAN;
        if (half_is_nan(a)) return b;
        if (half_is_nan(b)) return a;
        // signed zeros: min prefers -0, max prefers +0
        if (a[14:0] == 15'h0 && b[14:0] == 15'h0)
            return want_max ? {a[15] & b[15], 15'h0} : {a[15] | b[15], 15'h0};
        if (want_max) return half_less(a, b) ? b : a;
        return half_less(b, a) ? b : a;
    endfunction

    function automatic logic [9:0] half_class(input logic [15:0] h);
        if (h[14:10] == 5'h1F) begin
            if (h[9:0] == 10'h0) return h[15] ? 10'h001 : 10'h080;
            return h[9] ? 10'h200 : 10'h100;
        end
        if (h[14:10] == 5'h0) begin
            if (h[9:0] == 10'h0) return h[15] ? 10'h008 : 10'h010;
            return h[15] ? 10'h004 : 10'h020;
        end
        return h[15] ? 10'h002 : 10'h040;
    endfunction

    // expected result word and flag of one request
    function automatic t_outcome predict_outcome(input t_func f, input t_rm rm,
                                                 input logic [31:0] a, input logic [15:0] b);
        t_outcome    o;
        logic [15:0] ah;
        logic        no_nan;
        ah        = a[15:0];
        no_nan    = !half_is_nan(ah) && !half_is_nan(b);
        o.func    = f;
        o.result  = 32'h0;
        o.illegal = 1'b0;
        case (f)
            FN_SGNJ:     o.result = {16'h0, b[15], ah[14:0]};
            FN_SGNJN:    o.result = {16'h0, ~b[15], ah[14:0]};
            FN_SGNJX:    o.result = {16'h0, ah[15] ^ b[15], ah[14:0]};
            FN_MIN:      o.result = {16'h0, pick_min_max(ah, b, 1'b0)};
            FN_MAX:      o.result = {16'h0, pick_min_max(ah, b, 1'b1)};
            FN_EQ:       o.result = {31'h0, no_nan && (ah == b ||
                                            (ah[14:0] == 15'h0 && b[14:0] == 15'h0))};
            FN_LT:       o.result = {31'h0, no_nan && half_less(ah, b)};
            FN_LE:       o.result = {31'h0, no_nan && !half_less(b, ah)};
            FN_CVT_H_W:  o.result = {16'h0, a[31] ? half_from_magnitude(-a, 1'b1, rm)
                                                   : half_from_magnitude(a, 1'b0, rm)};
            FN_CVT_H_WU: o.result = {16'h0, half_from_magnitude(a, 1'b0, rm)};
            FN_CVT_W_H: begin
                if (ah[14:10] == 5'h1F)
                    o.result = (ah[9:0] == 10'h0 && ah[15]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                else if (ah[14:10] == 5'h0)
                    o.result = 32'h0;
                else
                    o.result = ah[15] ? -magnitude_from_half(ah, rm)
                                      : magnitude_from_half(ah, rm);
            end
            FN_CVT_WU_H: begin
                if (ah[15] || ah[14:10] == 5'h0) o.result = 32'h0;
                else if (ah[14:10] == 5'h1F)     o.result = 32'hFFFF_FFFF;
                else                             o.result = magnitude_from_half(ah, rm);
            end
            FN_MV_X_H:   o.result = {{16{ah[15]}}, ah};
            FN_CLASS:    o.result = {22'h0, half_class(ah)};
            FN_MV_H_X:   o.result = {16'h0, ah};
            default:     o.illegal = 1'b1;
        endcase
        return o;
    endfunction

    // ---------------- stimulus ----------------

    // half value biased toward zeros, subnormals, infinities, nans and integer range
    function automatic logic [15:0] rand_half();
        logic [15:0] h;
        h = 16'($urandom());
        case ($urandom_range(0, 7))
            0: h[14:0] = 15'h0;
            1: h[14:10] = 5'h0;
            2: begin
                h[14:10] = 5'h1F;
                h[9:0]   = 10'h0;
            end
            3: begin
                h[14:10] = 5'h1F;
                if (h[9:0] == 10'h0) h[0] = 1'b1;
            end
            4: h[14:10] = 5'($urandom_range(15, 30));
            default: ;
        endcase
        return h;
    endfunction

    task automatic report_mismatch(input string field, input t_func f,
                                   input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: func %s got %h expected %h", field, f.name(), got, want);
        mismatch_count++;
    endtask

    // hold one request until taken, with an optional random gap in front
    task automatic issue_request(input t_func f, input t_rm rm, input logic [31:0] a,
                                 input logic [15:0] b, input t_outcome want,
                                 input bit allow_gaps);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= f;
        i_rounding_mode <= rm;
        i_op_a          <= a;
        i_op_b          <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_outcomes.push_back(want);
    endtask

    initial begin : stimulus
        t_func       f;
        t_rm         rm;
        logic [31:0] a;
        logic [31:0] word;
        logic [15:0] b;
        t_outcome    want;
        int          len;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].fixed)
                want = '{directed_rows[r].func, directed_rows[r].result,
                         directed_rows[r].illegal};
            else
                want = predict_outcome(directed_rows[r].func, directed_rows[r].rm,
                                       directed_rows[r].op_a, directed_rows[r].op_b);
            issue_request(directed_rows[r].func, directed_rows[r].rm, directed_rows[r].op_a,
                          directed_rows[r].op_b, want, 1'b1);
        end

        // random requests, the last stretch back to back
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            f  = t_func'($urandom_range(0, 15));
            rm = t_rm'($urandom_range(0, 7));
            b  = rand_half();
            if (f == FN_CVT_H_W || f == FN_CVT_H_WU) begin
                case ($urandom_range(0, 3))
                    0: a = $urandom();
                    1: begin
                        len = $urandom_range(1, 32);
                        a   = $urandom();
                        if (len < 32) a = a & ((32'd1 << len) - 32'd1);
                        a[len-1] = 1'b1;
                    end
                    // around the largest finite half
                    2: a = 32'd65480 + 32'($urandom_range(0, 48));
                    default: a = 32'($urandom_range(0, 4096));
                endcase
                if (f == FN_CVT_H_W && $urandom_range(0, 1) == 1) a = -a;
            end else begin
                word = $urandom();
                a    = {word[31:16], rand_half()};
                // equal and sign-flipped pairs for the compares
                case ($urandom_range(0, 7))
                    0: b = a[15:0];
                    1: b = a[15:0] ^ 16'h8000;
                    default: ;
                endcase
            end
            want = predict_outcome(f, rm, a, b);
            issue_request(f, rm, a, b, want, n < RANDOM_ITEMS - QUIET_ITEMS);
        end
        start <= 1'b0;

        // drain
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ---------------- checking ----------------

    // compare each shown result with the oldest pending request
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", FN_UNSUP, o_result, 32'h0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_result !== want.result)
                    report_mismatch("result", want.func, o_result, want.result);
                if (o_illegal !== want.illegal)
                    report_mismatch("illegal", want.func, {31'h0, o_illegal},
                                    {31'h0, want.illegal});
            end
        end else if (i_rst_n && o_valid !== 1'b0) begin
            report_mismatch("valid unknown", FN_UNSUP, {31'h0, o_valid}, 32'h0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
